// ===== hw/rtl/pa_pkg.sv =====
// Shared types and constants of the primitive assembler.
package pa_pkg;

  // Topology codes carried on the operation field; code 7 is unused.
  typedef enum logic [2:0] {
    TOPO_TRI_LIST    = 3'd0,
    TOPO_QUAD        = 3'd1,
    TOPO_FAN         = 3'd2,
    TOPO_STRIP       = 3'd3,
    TOPO_LINE_LIST   = 3'd4,
    TOPO_LINE_STRIP  = 3'd5,
    TOPO_LINE_LOOP   = 3'd6
  } topo_t;

  localparam int VTX_BITS = 16;
  localparam int MAX_EMIT = 4;
  localparam int CNT_BITS = 3;
  localparam int IDX_BITS = 2;
  // power of two
  localparam int CQ_DEPTH = 2;

  localparam logic STREAM_TRI  = 1'b0;
  localparam logic STREAM_LINE = 1'b1;

  // One classified input: the vertices it emits, in order, and their stream.
  typedef struct packed {
    logic                               stream;
    logic [CNT_BITS-1:0]                count;
    logic [MAX_EMIT-1:0][VTX_BITS-1:0]  vtx;
  } pa_cmd_t;

endpackage

// ===== hw/rtl/pa_front.sv =====
// Front end: tracks group state and turns vertices into emit commands.
module pa_front #(
  parameter int KEEP_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [2:0]              operation,
  input  logic [15:0]             vertex_handle,
  input  logic                    group_end,
  output pa_pkg::pa_cmd_t         cmd,
  output logic                    cmd_push
);
  import pa_pkg::*;

  logic [KEEP_BITS-1:0] first_vertex, first_vertex_next;
  logic [KEEP_BITS-1:0] older_vertex, older_vertex_next;
  logic [KEEP_BITS-1:0] newer_vertex, newer_vertex_next;
  logic [1:0]           group_position, group_position_next;
  logic                 strip_parity, strip_parity_next;
  logic [KEEP_BITS-1:0] v;
  logic [1:0]           pos_sat;

  function automatic logic [VTX_BITS-1:0] ext(input logic [KEEP_BITS-1:0] h);
    return VTX_BITS'(h);
  endfunction

  assign v       = vertex_handle[KEEP_BITS-1:0];
  assign pos_sat = (group_position == 2'd3) ? 2'd3 : group_position + 2'd1;

  always_comb begin
    first_vertex_next   = first_vertex;
    older_vertex_next   = older_vertex;
    newer_vertex_next   = newer_vertex;
    strip_parity_next   = strip_parity;
    group_position_next = pos_sat;
    cmd                 = '0;
    unique case (topo_t'(operation))
      TOPO_TRI_LIST: begin
        cmd.stream = STREAM_TRI;
        cmd.count  = CNT_BITS'(1);
        cmd.vtx[0] = ext(v);
      end
      TOPO_QUAD: begin
        cmd.stream = STREAM_TRI;
        unique case (group_position)
          2'd0: first_vertex_next = v;
          2'd1: older_vertex_next = v;
          2'd2: begin
            cmd.count  = CNT_BITS'(3);
            cmd.vtx[0] = ext(first_vertex);
            cmd.vtx[1] = ext(older_vertex);
            cmd.vtx[2] = ext(v);
            newer_vertex_next = v;
          end
          default: begin
            cmd.count  = CNT_BITS'(3);
            cmd.vtx[0] = ext(first_vertex);
            cmd.vtx[1] = ext(newer_vertex);
            cmd.vtx[2] = ext(v);
          end
        endcase
        // corner index wraps within a quad
        group_position_next = group_position + 2'd1;
      end
      TOPO_FAN: begin
        cmd.stream = STREAM_TRI;
        if (group_position == 2'd0) begin
          first_vertex_next = v;
        end
        if (group_position[1]) begin
          cmd.count  = CNT_BITS'(3);
          cmd.vtx[0] = ext(first_vertex);
          cmd.vtx[1] = ext(newer_vertex);
          cmd.vtx[2] = ext(v);
        end
        older_vertex_next = newer_vertex;
        newer_vertex_next = v;
      end
      TOPO_STRIP: begin
        cmd.stream = STREAM_TRI;
        if (group_position == 2'd0) begin
          first_vertex_next = v;
        end
        if (group_position[1]) begin
          cmd.count  = CNT_BITS'(3);
          // swap on odd triangles to keep the winding
          cmd.vtx[0] = strip_parity ? ext(newer_vertex) : ext(older_vertex);
          cmd.vtx[1] = strip_parity ? ext(older_vertex) : ext(newer_vertex);
          cmd.vtx[2] = ext(v);
          strip_parity_next = ~strip_parity;
        end
        older_vertex_next = newer_vertex;
        newer_vertex_next = v;
      end
      TOPO_LINE_LIST: begin
        cmd.stream = STREAM_LINE;
        cmd.count  = CNT_BITS'(1);
        cmd.vtx[0] = ext(v);
      end
      TOPO_LINE_STRIP, TOPO_LINE_LOOP: begin
        cmd.stream = STREAM_LINE;
        if (group_position == 2'd0) begin
          first_vertex_next = v;
        end else begin
          cmd.count  = CNT_BITS'(2);
          cmd.vtx[0] = ext(newer_vertex);
          cmd.vtx[1] = ext(v);
          // close the loop back to its first vertex
          if ((topo_t'(operation) == TOPO_LINE_LOOP) && group_end) begin
            cmd.count  = CNT_BITS'(4);
            cmd.vtx[2] = ext(v);
            cmd.vtx[3] = ext(first_vertex);
          end
        end
        older_vertex_next = newer_vertex;
        newer_vertex_next = v;
      end
      default: begin
        group_position_next = group_position;
      end
    endcase
    if (group_end) begin
      group_position_next = 2'd0;
      strip_parity_next   = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vertex   <= '0;
      older_vertex   <= '0;
      newer_vertex   <= '0;
      group_position <= '0;
      strip_parity   <= 1'b0;
    end else if (accept) begin
      first_vertex   <= first_vertex_next;
      older_vertex   <= older_vertex_next;
      newer_vertex   <= newer_vertex_next;
      group_position <= group_position_next;
      strip_parity   <= strip_parity_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && group_end) |=> (group_position == 2'd0 && !strip_parity))
    else $error("group end did not clear position and parity");

endmodule

// ===== hw/rtl/pa_queue.sv =====
// Short command queue between the front end and the emitter.
module pa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pa_pkg::pa_cmd_t  wr_data,
  input  logic             rd,
  output logic             full,
  output logic             valid,
  output pa_pkg::pa_cmd_t  rd_data
);
  import pa_pkg::*;

  localparam int PTR_BITS = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CNT_W    = $clog2(CQ_DEPTH + 1);

  pa_cmd_t             mem [CQ_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full    = (count == CNT_W'(CQ_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full && !rd))
    else $error("command queue written while full");

endmodule

// ===== hw/rtl/pa_back.sv =====
// Emitter: walks each queued command one vertex per beat into the output register.
module pa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pa_pkg::pa_cmd_t  q_cmd,
  output logic             deq,
  input  logic             pop,
  output logic             empty,
  output logic [15:0]      out_vertex,
  output logic             target_stream,
  output logic             run_last
);
  import pa_pkg::*;

  logic                idx;
  logic [IDX_BITS-1:0] vidx;
  logic                out_valid;
  logic                load;
  logic                last;

  // vidx is the vertex slot within the current command
  assign idx   = 1'b0;
  assign empty = !out_valid;
  assign load  = q_valid && (!out_valid || pop);
  assign last  = ({idx, vidx} + CNT_BITS'(1)) == q_cmd.count;
  assign deq   = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      vidx      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      vidx      <= last ? '0 : vidx + 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vertex    <= q_cmd.vtx[vidx];
      target_stream <= q_cmd.stream;
      run_last      <= last;
    end
  end

  a_cmd_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_cmd.count != '0))
    else $error("queued command emits no vertex");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> ({idx, vidx} < q_cmd.count))
    else $error("vertex slot beyond command length");

endmodule

// ===== hw/rtl/primitive_assembler.sv =====
// Primitive assembler top level: vertex queue in, list-stream queue out.
//
// Input channel: one vertex handle per beat with its topology (operation)
// and a group_end mark; a beat is taken when push is high and full is low.
// Output channel: one list-stream vertex per beat; while empty is low the
// oldest vertex is on out_vertex/target_stream/run_last and leaves when
// pop is high. run_last marks the final vertex produced by an input.
// Each input produces 0 to 4 output beats (4 only when a line loop closes).
// An input's command is registered in the command queue, its first vertex
// then in the output register. Throughput: one output vertex per cycle, set
// by the emitter, while the receiver pops; a fan or strip triangle is 3
// vertices, a list input 1. A two-entry command queue between the classifier
// and the emitter lets input keep flowing while output drains.
// Reset (rst, synchronous) clears the group state and empties both the
// command queue and the output register. When the receiver stops popping,
// the output register holds, the queue fills and full rises.
module primitive_assembler #(
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [15:0] vertex_handle,
  input  logic        group_end,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_vertex,
  output logic        target_stream,
  output logic        run_last
);
  import pa_pkg::*;

  localparam int KEEP_BITS = (HANDLE_BITS < VTX_BITS) ? HANDLE_BITS : VTX_BITS;

  logic    accept;
  logic    cmd_push;
  pa_cmd_t cmd;
  pa_cmd_t q_cmd;
  logic    q_valid;
  logic    deq;

  assign accept = push && !full;

  pa_front #(.KEEP_BITS(KEEP_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .vertex_handle (vertex_handle),
    .group_end     (group_end),
    .cmd           (cmd),
    .cmd_push      (cmd_push)
  );

  pa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd),
    .rd      (deq),
    .full    (full),
    .valid   (q_valid),
    .rd_data (q_cmd)
  );

  pa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .deq           (deq),
    .pop           (pop),
    .empty         (empty),
    .out_vertex    (out_vertex),
    .target_stream (target_stream),
    .run_last      (run_last)
  );

endmodule
